FILE: hw/rtl/fds_pkg.sv
// fds_pkg: shared types and constants for the frame duration sequencer
// used by the channel interfaces, the adder unit and the top level
package fds_pkg;

    localparam int MAX_FRAMES = 64;
    localparam int DUR_BITS = 24;
    localparam int REM_BITS = DUR_BITS + 1;
    localparam int SLOT_BITS = 6;
    localparam int INDEX_BITS = 6;
    localparam int COUNT_BITS = 7;
    localparam int CFG_DATA_BITS = 7;

    typedef logic [DUR_BITS-1:0] dur_t;
    typedef logic signed [REM_BITS-1:0] rem_t;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_RESTART = 2'd1,
        OP_WRITE   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic {
        CFG_FRAME_COUNT = 1'b0,
        CFG_LOOP_ENABLE = 1'b1
    } cfg_idx_t;

    // control from the sequencer to the shared adder
    typedef struct packed {
        logic subtract;
    } alu_ctrl_t;

endpackage

FILE: hw/rtl/fds_cmd_if.sv
// fds_cmd_if: input channel of the frame duration sequencer
// depends on fds_pkg for the opcode and duration types
interface fds_cmd_if
    import fds_pkg::*;
();
    logic                 valid;
    logic                 ready;
    op_t                  operation;
    dur_t                 elapsed;
    logic [SLOT_BITS-1:0] frame_slot;
    dur_t                 duration;

    modport source (output valid, operation, elapsed, frame_slot, duration, input ready);
    modport sink (input valid, operation, elapsed, frame_slot, duration, output ready);
endinterface

FILE: hw/rtl/fds_status_if.sv
// fds_status_if: result channel of the frame duration sequencer
// depends on fds_pkg for the remaining time type
interface fds_status_if
    import fds_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] frame_pos;
    rem_t                  remaining_time;
    logic                  finished;
    logic                  overrun;

    modport source (output valid, frame_pos, remaining_time, finished, overrun, input ready);
    modport sink (input valid, frame_pos, remaining_time, finished, overrun, output ready);
endinterface

FILE: hw/rtl/fds_ram.sv
// fds_ram: generic single write port, single read port RAM with registered read
// no dependencies
module fds_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hw/rtl/fds_alu.sv
// fds_alu: shared add/subtract unit for the remaining time, saturating at the low bound
// depends on fds_pkg
module fds_alu
    import fds_pkg::*;
(
    input  alu_ctrl_t ctrl,
    input  rem_t      acc,
    input  dur_t      operand,
    output rem_t      result
);
    localparam logic signed [REM_BITS:0] SUM_LOW = -$signed({2'b00, {DUR_BITS{1'b1}}});

    logic signed [REM_BITS:0] ext_acc;
    logic signed [REM_BITS:0] ext_op;
    logic signed [REM_BITS:0] sum;

    always_comb
    begin
        ext_acc = {acc[REM_BITS-1], acc};
        ext_op  = $signed({2'b00, operand});
        sum     = ctrl.subtract ? (ext_acc - ext_op) : (ext_acc + ext_op);
        if (sum < SUM_LOW)
        begin
            result = SUM_LOW[REM_BITS-1:0];
        end
        else
        begin
            result = sum[REM_BITS-1:0];
        end
    end
endmodule

FILE: hw/rtl/frame_duration_sequencer_unit.sv
// frame_duration_sequencer_unit: top level, sequencer around the duration RAM and adder
// depends on fds_pkg, fds_cmd_if, fds_status_if, fds_ram, fds_alu
//
// usage:
//   cmd carries one beat per item: tick (subtract elapsed, advance frames),
//   restart (frame 0, load its duration), duration write into the table or no-op.
//   status returns exactly one beat per item with frame, remaining time and flags.
//   cfg_write/cfg_index/cfg_data set frame_count and loop_enable; the user must
//   write them only while idle, which the block itself does not enforce.
// timing:
//   write, no-op and a tick with no frames go from the accepting edge to the done
//   state, restart loads duration entry 0 first, and a tick subtracts elapsed and
//   advances frames, at most MAX_ADVANCE; each advance is one duration RAM read
//   followed by one pass through the adder; the result loads from the done state.
//   cmd.ready is high only while idle: no new beat is taken until the result loads.
// reset:
//   frame 0, remaining time 0, registers 0; table contents undefined until written.
// stall:
//   status has an output register; the next item is accepted while a result waits,
//   and a finished item holds in the sequencer until the output register frees up.
module frame_duration_sequencer_unit
    import fds_pkg::*;
#(
    parameter int MAX_ADVANCE = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    fds_cmd_if.sink                  cmd,
    fds_status_if.source             status,
    input  logic                     cfg_write,
    input  cfg_idx_t                 cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);
    localparam int FRAME_BITS = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int STEP_BITS  = $clog2(MAX_ADVANCE + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUB,
        S_CHECK,
        S_ADD,
        S_LOAD,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic [COUNT_BITS-1:0]   frame_count_reg;
    logic                    loop_enable_reg;
    logic [FRAME_BITS-1:0]   cur_frame_reg;
    rem_t                    time_left_reg;
    logic [STEP_BITS-1:0]    steps_reg;
    dur_t                    elapsed_reg;
    logic                    overrun_reg;
    logic                    out_valid_reg;
    logic [INDEX_BITS-1:0]   out_frame_reg;
    rem_t                    out_time_reg;
    logic                    out_finished_reg;
    logic                    out_overrun_reg;

    logic [COUNT_BITS-1:0]   used_count;
    logic                    at_last;
    logic                    stopped;
    logic [FRAME_BITS-1:0]   next_frame;
    logic                    accept;
    logic                    slot_ok;
    logic                    ram_we;
    logic [FRAME_BITS-1:0]   ram_raddr;
    dur_t                    ram_rdata;
    alu_ctrl_t               alu_ctrl;
    dur_t                    alu_operand;
    rem_t                    alu_result;
    logic                    out_free;

    always_comb
    begin
        used_count = (32'(frame_count_reg) > MAX_FRAMES) ? COUNT_BITS'(MAX_FRAMES)
                                                         : frame_count_reg;
        at_last    = (32'(cur_frame_reg) + 32'd1) >= 32'(used_count);
        stopped    = at_last && !loop_enable_reg;
        next_frame = at_last ? '0 : cur_frame_reg + FRAME_BITS'(1);
        accept     = cmd.valid && cmd.ready;
        slot_ok    = 32'(cmd.frame_slot) < MAX_FRAMES;
        ram_we     = accept && (cmd.operation == OP_WRITE) && slot_ok;
        // restart reads entry 0 from idle, advances read the next frame
        ram_raddr  = (state_reg == S_CHECK) ? next_frame : '0;
        alu_ctrl.subtract = (state_reg == S_SUB);
        alu_operand = alu_ctrl.subtract ? elapsed_reg : ram_rdata;
        out_free   = !out_valid_reg || status.ready;
    end

    assign cmd.ready             = (state_reg == S_IDLE);
    assign status.valid          = out_valid_reg;
    assign status.frame_pos      = out_frame_reg;
    assign status.remaining_time = out_time_reg;
    assign status.finished       = out_finished_reg;
    assign status.overrun        = out_overrun_reg;

    fds_ram #(
        .WIDTH (DUR_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_durations (
        .clk   (clk),
        .we    (ram_we),
        .waddr (FRAME_BITS'(cmd.frame_slot)),
        .wdata (cmd.duration),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fds_alu u_alu (
        .ctrl    (alu_ctrl),
        .acc     (time_left_reg),
        .operand (alu_operand),
        .result  (alu_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            frame_count_reg  <= '0;
            loop_enable_reg  <= 1'b0;
            cur_frame_reg    <= '0;
            time_left_reg    <= '0;
            steps_reg        <= '0;
            elapsed_reg      <= '0;
            overrun_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_frame_reg    <= '0;
            out_time_reg     <= '0;
            out_finished_reg <= 1'b0;
            out_overrun_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_FRAME_COUNT: frame_count_reg <= cfg_data;
                    CFG_LOOP_ENABLE: loop_enable_reg <= cfg_data[0];
                    default:         ;
                endcase
            end

            // in the done state the output register is reloaded below instead
            if (out_valid_reg && status.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        overrun_reg <= 1'b0;
                        elapsed_reg <= cmd.elapsed;
                        unique case (cmd.operation)
                            OP_TICK:
                            begin
                                state_reg <= (used_count == '0) ? S_DONE : S_SUB;
                            end
                            OP_RESTART:
                            begin
                                cur_frame_reg <= '0;
                                state_reg     <= S_LOAD;
                            end
                            OP_WRITE: state_reg <= S_DONE;
                            OP_NONE:  state_reg <= S_DONE;
                            default:  state_reg <= S_DONE;
                        endcase
                    end
                end
                S_SUB:
                begin
                    time_left_reg <= alu_result;
                    steps_reg     <= '0;
                    state_reg     <= S_CHECK;
                end
                S_CHECK:
                begin
                    priority if (!time_left_reg[REM_BITS-1] || stopped)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (steps_reg >= STEP_BITS'(MAX_ADVANCE))
                    begin
                        overrun_reg <= 1'b1;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        cur_frame_reg <= next_frame;
                        state_reg     <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    time_left_reg <= alu_result;
                    steps_reg     <= steps_reg + STEP_BITS'(1);
                    state_reg     <= S_CHECK;
                end
                S_LOAD:
                begin
                    time_left_reg <= (used_count == '0) ? '0 : $signed({1'b0, ram_rdata});
                    state_reg     <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_frame_reg    <= INDEX_BITS'(cur_frame_reg);
                        out_time_reg     <= time_left_reg;
                        out_finished_reg <= !loop_enable_reg && at_last &&
                                            (time_left_reg[REM_BITS-1] || time_left_reg == '0);
                        out_overrun_reg  <= overrun_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_overrun_negative: assert property (@(posedge clk) disable iff (!rst_n)
        status.valid && status.overrun |-> status.remaining_time[REM_BITS-1])
        else $error("overrun reported with non-negative remaining time");

    a_finished_not_positive: assert property (@(posedge clk) disable iff (!rst_n)
        status.valid && status.finished |->
            (status.remaining_time[REM_BITS-1] || status.remaining_time == '0))
        else $error("finished reported with positive remaining time");

    a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(steps_reg) <= MAX_ADVANCE)
        else $error("advance counter beyond limit");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("new beat taken while an item is in work");
`endif

endmodule
